/* rtl/alpha_outline_dilation_3x3_unit_defines.svh */
// Assertion helpers shared by the checkers of the outline dilation unit.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ALPHA_OUTLINE_DILATION_3X3_UNIT_DEFINES_SVH
`define ALPHA_OUTLINE_DILATION_3X3_UNIT_DEFINES_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define AOD3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define AOD3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aod3_pkg.sv */
package aod3_pkg;

    // Widths fixed by the register map and the item fields.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int COORD_W     = 11;
    localparam int PIX_W       = 8;

    typedef logic [PIX_W-1:0]   pix8_t;
    typedef logic [COORD_W-1:0] coord_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE_RED   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE_GREEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE_BLUE  = 3'd4;

    // Position flags that travel with an item from acceptance into the burst stage.
    typedef struct packed {
        logic x_last;
        logic y_last;
        logic y_ge1;
        logic y_ge2;
        logic fwd_hit;
    } item_flags_t;

endpackage

/* rtl/aod3_ram.sv */
module aod3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Registered read; the output holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* rtl/alpha_outline_dilation_3x3_unit.sv */
// Outline dilation unit: a 3x3 maximum filter over the alpha of a source image.
// Source alphas arrive on the input channel (in_valid, in_stall, source_alpha)
// in raster order over a frame of image_width by image_height pixels. Each
// result item on the output channel is one pixel of the outline layer, two
// pixels wider and two taller than the source, carrying the outline colour and
// the largest source alpha of the 3x3 window that ends at out_column, out_row.
// An accepted item is registered in the burst stage, whose results go to the
// output register. An item in the body of the image gives one result, and the
// unit takes one item per cycle while the output does not stall. An item on
// the last column gives three results, one on the last row three, and the
// bottom right item nine; the output register sends one result per cycle
// while out_stall is low, so such an item keeps the burst stage busy and
// holds the input until its final result, the next item being taken with it.
// The output register parts the two sides, so a new item is taken while a
// finished result still waits. When the receiver raises out_stall the result
// holds, the burst stage pauses and in_stall rises once that stage is full.
// Reset sets the size to one by one, the colour to black and the frame to its
// start; the line store needs no clearing, since a row is read only after it
// has been written. Writing the width or the height restarts the frame.
module alpha_outline_dilation_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [aod3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aod3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  aod3_pkg::pix8_t                    source_alpha,
    output logic                               out_valid,
    input  logic                               out_stall,
    output aod3_pkg::coord_t                   out_column,
    output aod3_pkg::coord_t                   out_row,
    output aod3_pkg::pix8_t                    red,
    output aod3_pkg::pix8_t                    green,
    output aod3_pkg::pix8_t                    blue,
    output aod3_pkg::pix8_t                    alpha,
    output logic                               last_of_burst,
    output logic                               end_of_image
);

    import aod3_pkg::*;

    // Position counters index up to the maximum minus one; sizes hold the maximum.
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    function automatic pix8_t max8(input pix8_t a, input pix8_t b);
        return (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    pix8_t                 outline_red_reg;
    pix8_t                 outline_green_reg;
    pix8_t                 outline_blue_reg;
    logic                  restart;

    assign restart = cfg_wr_en &&
                     ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= CFG_DATA_W'(1);
            image_height_reg  <= CFG_DATA_W'(1);
            outline_red_reg   <= '0;
            outline_green_reg <= '0;
            outline_blue_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_OUTLINE_RED:   outline_red_reg   <= cfg_data[PIX_W-1:0];
                REG_OUTLINE_GREEN: outline_green_reg <= cfg_data[PIX_W-1:0];
                REG_OUTLINE_BLUE:  outline_blue_reg  <= cfg_data[PIX_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, larger values saturate.
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = WW'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            height_eff = HW'(1);
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            height_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HW'(image_height_reg);
        end
    end

    // Raster position of the next source pixel.
    logic [XW-1:0] x_pos_reg, x_pos_next;
    logic [YW-1:0] y_pos_reg, y_pos_next;
    item_flags_t   in_flags;
    logic          in_accept;

    // Burst stage: the item whose results are being sent.
    logic          s1_valid_reg, s1_valid_next;
    pix8_t         s1_alpha_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    item_flags_t   s1_flags_reg;
    logic [1:0]    row_idx_reg, row_idx_next;
    logic [1:0]    col_idx_reg, col_idx_next;
    logic          s1_leave;
    logic          out_load;
    logic          burst_last;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = s1_valid_reg && !s1_leave;

    always_comb
    begin
        in_flags.x_last  = (WW'(x_pos_reg) == (width_eff - WW'(1)));
        in_flags.y_last  = (HW'(y_pos_reg) == (height_eff - HW'(1)));
        in_flags.y_ge1   = (y_pos_reg != '0);
        in_flags.y_ge2   = (HW'(y_pos_reg) > HW'(1));
        // The write of the leaving item lands on the same edge as this read.
        in_flags.fwd_hit = s1_leave && (s1_x_reg == x_pos_reg);
    end

    always_comb
    begin
        x_pos_next = x_pos_reg;
        y_pos_next = y_pos_reg;
        if (restart)
        begin
            x_pos_next = '0;
            y_pos_next = '0;
        end
        else if (in_accept)
        begin
            if (in_flags.x_last)
            begin
                x_pos_next = '0;
                y_pos_next = in_flags.y_last ? '0 : y_pos_reg + YW'(1);
            end
            else
            begin
                x_pos_next = x_pos_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg <= '0;
            y_pos_reg <= '0;
        end
        else
        begin
            x_pos_reg <= x_pos_next;
            y_pos_reg <= y_pos_next;
        end
    end

    // Line store: one entry per column, the row above in the low byte and the
    // row two above in the high byte. Read at acceptance, written when the item
    // leaves the burst stage.
    logic [2*PIX_W-1:0] line_rd;
    pix8_t              fwd_one_reg;
    pix8_t              fwd_two_reg;
    pix8_t              up1_raw;
    pix8_t              up2_raw;

    assign up1_raw = s1_flags_reg.fwd_hit ? fwd_one_reg : line_rd[PIX_W-1:0];
    assign up2_raw = s1_flags_reg.fwd_hit ? fwd_two_reg : line_rd[2*PIX_W-1:PIX_W];

    aod3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_leave),
        .wr_addr (s1_x_reg),
        .wr_data ({up1_raw, s1_alpha_reg}),
        .rd_en   (in_accept),
        .rd_addr (x_pos_reg),
        .rd_data (line_rd)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_alpha_reg <= source_alpha;
            s1_x_reg     <= x_pos_reg;
            s1_y_reg     <= y_pos_reg;
            s1_flags_reg <= in_flags;
            fwd_one_reg  <= s1_alpha_reg;
            fwd_two_reg  <= up1_raw;
        end
    end

    // Vertical maxima of the current column over three, two and one rows.
    pix8_t cur [3];

    always_comb
    begin
        cur[2] = s1_alpha_reg;
        cur[1] = max8(s1_alpha_reg, s1_flags_reg.y_ge1 ? up1_raw : '0);
        cur[0] = max8(cur[1], s1_flags_reg.y_ge2 ? up2_raw : '0);
    end

    // Maxima of the previous two columns, per depth: [2*depth] one column back,
    // [2*depth+1] two columns back. They count as zero at the start of a row.
    pix8_t rcm_reg [6];
    pix8_t rcm_eff [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            rcm_eff[i] = (s1_x_reg == '0) ? '0 : rcm_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                rcm_reg[i] <= '0;
            end
        end
        else if (restart)
        begin
            for (int i = 0; i < 6; i++)
            begin
                rcm_reg[i] <= '0;
            end
        end
        else if (s1_leave)
        begin
            for (int d = 0; d < 3; d++)
            begin
                rcm_reg[2*d+1] <= rcm_eff[2*d];
                rcm_reg[2*d]   <= cur[d];
            end
        end
    end

    // Window value of the result at the current burst position. The row index
    // selects the depth, the column index how many earlier columns still count.
    pix8_t cur_sel;
    pix8_t m1_sel;
    pix8_t m2_sel;
    pix8_t win_max;

    always_comb
    begin
        unique case (row_idx_reg)
            2'd0:
            begin
                cur_sel = cur[0];
                m1_sel  = rcm_eff[0];
                m2_sel  = rcm_eff[1];
            end
            2'd1:
            begin
                cur_sel = cur[1];
                m1_sel  = rcm_eff[2];
                m2_sel  = rcm_eff[3];
            end
            default:
            begin
                cur_sel = cur[2];
                m1_sel  = rcm_eff[4];
                m2_sel  = rcm_eff[5];
            end
        endcase

        unique case (col_idx_reg)
            2'd0:    win_max = max8(cur_sel, max8(m1_sel, m2_sel));
            2'd1:    win_max = max8(cur_sel, m1_sel);
            default: win_max = cur_sel;
        endcase
    end

    // Burst sequencing: rows outer, columns inner.
    logic [1:0] row_end;
    logic [1:0] col_end;

    assign row_end    = s1_flags_reg.y_last ? 2'd2 : 2'd0;
    assign col_end    = s1_flags_reg.x_last ? 2'd2 : 2'd0;
    assign burst_last = (row_idx_reg == row_end) && (col_idx_reg == col_end);
    assign out_load   = s1_valid_reg && (!out_valid || !out_stall);
    assign s1_leave   = out_load && burst_last;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        row_idx_next  = row_idx_reg;
        col_idx_next  = col_idx_reg;
        if (s1_leave)
        begin
            s1_valid_next = 1'b0;
            row_idx_next  = '0;
            col_idx_next  = '0;
        end
        else if (out_load)
        begin
            if (col_idx_reg == col_end)
            begin
                col_idx_next = '0;
                row_idx_next = row_idx_reg + 2'd1;
            end
            else
            begin
                col_idx_next = col_idx_reg + 2'd1;
            end
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            row_idx_reg  <= '0;
            col_idx_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            row_idx_reg  <= row_idx_next;
            col_idx_reg  <= col_idx_next;
        end
    end

    // Output register.
    logic out_valid_reg, out_valid_next;

    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_column    <= COORD_W'(s1_x_reg) + COORD_W'(col_idx_reg);
            out_row       <= COORD_W'(s1_y_reg) + COORD_W'(row_idx_reg);
            red           <= outline_red_reg;
            green         <= outline_green_reg;
            blue          <= outline_blue_reg;
            alpha         <= win_max;
            last_of_burst <= burst_last;
            end_of_image  <= (row_idx_reg == 2'd2) && (col_idx_reg == 2'd2);
        end
    end

endmodule

/* rtl/aod3_checker.sv */
`include "alpha_outline_dilation_3x3_unit_defines.svh"

module aod3_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [aod3_pkg::COORD_W-1:0] out_column,
    input logic [aod3_pkg::COORD_W-1:0] out_row,
    input logic                    last_of_burst,
    input logic                    end_of_image
);

    import aod3_pkg::*;

    // A stalled result holds its position and burst marks.
    `AOD3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_column) && $stable(out_row) && $stable(last_of_burst), "stalled output item changed")

    // The bottom right pixel closes the burst of the final source item.
    `AOD3_ASSERT_IMP(a_eoi_last, out_valid && end_of_image, last_of_burst, "end of image without end of burst")

    // The bottom right pixel lies past the source on both axes.
    `AOD3_ASSERT_IMP(a_eoi_corner, out_valid && end_of_image, (out_column > COORD_W'(1)) && (out_row > COORD_W'(1)), "end of image inside the source area")

    // A valid result is expected on the output after every accepted item.
    `AOD3_ASSERT_IMP(a_item_result, in_valid && !in_stall, ##2 out_valid, "accepted item gave no result")

endmodule

bind alpha_outline_dilation_3x3_unit aod3_checker u_aod3_checker (.*);
